### design/ths_pkg.sv
// Shared types, constants and helpers for the tar header stream scanner.
package ths_pkg;

	// Counter widths
	localparam int OFFSET_BITS = 32;
	localparam int INDEX_BITS  = 16;
	localparam int SIZE_BITS   = 36;
	localparam int SKIP_BITS   = 27;
	localparam int POS_BITS    = 9;

	// Byte positions inside a 512-byte header block
	localparam logic [POS_BITS-1:0] POS_NAME      = 9'd0;
	localparam logic [POS_BITS-1:0] POS_SIZE_LO   = 9'd124;
	localparam logic [POS_BITS-1:0] POS_SIZE_HI   = 9'd135;
	localparam logic [POS_BITS-1:0] POS_TYPEFLAG  = 9'd156;
	localparam logic [POS_BITS-1:0] POS_MAGIC_LO  = 9'd257;
	localparam logic [POS_BITS-1:0] POS_MAGIC_HI  = 9'd261;
	localparam logic [POS_BITS-1:0] POS_BLOCK_END = 9'd511;

	// Characters
	localparam logic [7:0] CHAR_ZERO  = 8'h30;
	localparam logic [7:0] CHAR_SEVEN = 8'h37;
	localparam logic [7:0] CHAR_FIVE  = 8'h35;

	// Result kinds
	localparam logic [1:0] KIND_ENTRY     = 2'd0;
	localparam logic [1:0] KIND_END       = 2'd1;
	localparam logic [1:0] KIND_BAD_MAGIC = 2'd2;
	localparam logic [1:0] KIND_TRUNCATED = 2'd3;

	// Scanner phase
	typedef enum logic [2:0] {
		PH_HEADER = 3'b001,
		PH_SKIP   = 3'b010,
		PH_DONE   = 3'b100
	} phase_t;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       last_byte;
	} in_item_t;

	typedef struct packed {
		logic [1:0]  kind;
		logic        is_directory;
		logic [31:0] data_start;
		logic [31:0] file_bytes;
		logic [15:0] entry_index;
	} out_item_t;

	// Expected magic text "ustar", one character per index
	function automatic logic [7:0] magic_char(input logic [2:0] idx);
		logic [7:0] c;
		unique case (idx)
			3'd0: c = 8'h75;
			3'd1: c = 8'h73;
			3'd2: c = 8'h74;
			3'd3: c = 8'h61;
			3'd4: c = 8'h72;
			default: c = 8'h00;
		endcase
		return c;
	endfunction

endpackage

### design/ths_scan.sv
// Header scanner: block position, field capture, data skipping and result build.
module ths_scan
	import ths_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      step,
	input  in_item_t  item_s1,
	output logic      hit,
	output out_item_t result
);

	phase_t                 phase_q, phase_d;
	logic [POS_BITS-1:0]    pos_q;
	logic [SIZE_BITS-1:0]   size_q, size_d;
	logic                   oct_stop_q, oct_stop_d;
	logic                   name_q, name_d;
	logic                   dir_q, dir_d;
	logic                   magic_ok_q, magic_ok_d;
	logic                   first_q, first_d;
	logic [SKIP_BITS-1:0]   skip_q, skip_d;
	logic [OFFSET_BITS-1:0] off_q, off_next;
	logic [INDEX_BITS-1:0]  entries_q, entries_d;

	logic [7:0]             b;
	logic                   hdr_end;
	logic                   in_size, in_magic, is_octal;
	logic [SKIP_BITS:0]     blocks;
	logic [OFFSET_BITS+31:0] off_ext;
	logic [INDEX_BITS+15:0]  idx_ext;
	logic [POS_BITS-1:0]    magic_pos;

	assign b        = item_s1.data_byte;
	assign off_next = off_q + 1'b1;
	assign hdr_end  = (phase_q == PH_HEADER) && (pos_q == POS_BLOCK_END);
	assign in_size  = (pos_q >= POS_SIZE_LO) && (pos_q <= POS_SIZE_HI);
	assign in_magic = (pos_q >= POS_MAGIC_LO) && (pos_q <= POS_MAGIC_HI);
	assign is_octal = (b >= CHAR_ZERO) && (b <= CHAR_SEVEN);
	assign magic_pos = pos_q - POS_MAGIC_LO;
	assign off_ext  = {{32{1'b0}}, off_next};
	assign idx_ext  = {{16{1'b0}}, entries_q};

	// data blocks covered by the size, rounded up
	assign blocks = {1'b0, size_q[SIZE_BITS-1:POS_BITS]}
		+ {{SKIP_BITS{1'b0}}, |size_q[POS_BITS-1:0]};

	// a result leaves on a header end, or on a last byte before any terminal result
	assign hit = hdr_end || (item_s1.last_byte && (phase_q != PH_DONE));

	// result fields
	always_comb begin
		result              = '0;
		result.entry_index  = idx_ext[15:0];
		if (hdr_end) begin
			if (first_q && !magic_ok_q) begin
				result.kind = KIND_BAD_MAGIC;
			end else if (!name_q) begin
				result.kind = KIND_END;
			end else begin
				result.kind         = KIND_ENTRY;
				result.is_directory = dir_q;
				if (!dir_q) begin
					result.data_start = off_ext[31:0];
					result.file_bytes = size_q[31:0];
				end
			end
		end else begin
			result.kind = KIND_TRUNCATED;
		end
	end

	// next state
	always_comb begin
		phase_d    = phase_q;
		size_d     = size_q;
		oct_stop_d = oct_stop_q;
		name_d     = name_q;
		dir_d      = dir_q;
		magic_ok_d = magic_ok_q;
		first_d    = first_q;
		skip_d     = skip_q;
		entries_d  = entries_q;

		unique case (phase_q)
			PH_HEADER: begin
				if (pos_q == POS_NAME) begin
					name_d = (b != 8'h00);
				end
				if (in_size && !oct_stop_q) begin
					if (is_octal) begin
						size_d = {size_q[SIZE_BITS-4:0], b[2:0]};
					end else begin
						oct_stop_d = 1'b1;
					end
				end
				if (pos_q == POS_TYPEFLAG) begin
					dir_d = (b == CHAR_FIVE);
				end
				if (in_magic && first_q && (b != magic_char(magic_pos[2:0]))) begin
					magic_ok_d = 1'b0;
				end
				if (hdr_end) begin
					first_d = 1'b0;
					if ((first_q && !magic_ok_q) || !name_q) begin
						phase_d = PH_DONE;
					end else begin
						if (entries_q != '1) begin
							entries_d = entries_q + 1'b1;
						end
						if (blocks == '0) begin
							phase_d = PH_HEADER;
						end else begin
							phase_d = PH_SKIP;
							skip_d  = SKIP_BITS'(blocks - 1'b1);
						end
					end
					size_d     = '0;
					oct_stop_d = 1'b0;
					name_d     = 1'b0;
					dir_d      = 1'b0;
				end
			end
			PH_SKIP: begin
				if (pos_q == POS_BLOCK_END) begin
					if (skip_q == '0) begin
						phase_d = PH_HEADER;
					end else begin
						skip_d = skip_q - 1'b1;
					end
				end
			end
			PH_DONE: begin
			end
			default: begin
				phase_d = PH_HEADER;
			end
		endcase
	end

	// state registers; the last byte re-arms for a new archive
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= PH_HEADER;
			pos_q      <= '0;
			size_q     <= '0;
			oct_stop_q <= 1'b0;
			name_q     <= 1'b0;
			dir_q      <= 1'b0;
			magic_ok_q <= 1'b1;
			first_q    <= 1'b1;
			skip_q     <= '0;
			off_q      <= '0;
			entries_q  <= '0;
		end else if (step) begin
			if (item_s1.last_byte) begin
				phase_q    <= PH_HEADER;
				pos_q      <= '0;
				size_q     <= '0;
				oct_stop_q <= 1'b0;
				name_q     <= 1'b0;
				dir_q      <= 1'b0;
				magic_ok_q <= 1'b1;
				first_q    <= 1'b1;
				skip_q     <= '0;
				off_q      <= '0;
				entries_q  <= '0;
			end else begin
				phase_q    <= phase_d;
				pos_q      <= pos_q + 1'b1;
				size_q     <= size_d;
				oct_stop_q <= oct_stop_d;
				name_q     <= name_d;
				dir_q      <= dir_d;
				magic_ok_q <= magic_ok_d;
				first_q    <= first_d;
				skip_q     <= skip_d;
				off_q      <= off_next;
				entries_q  <= entries_d;
			end
		end
	end

endmodule

### design/ths_out_reg.sv
// Result register holding one finished transaction until the sink takes it.
module ths_out_reg
	import ths_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      load,
	input  out_item_t load_data,
	output logic      free,
	output logic      res_valid,
	input  logic      res_stall,
	output out_item_t res
);

	logic      valid_q;
	out_item_t data_q;

	// slot can take a new result when empty or draining this cycle
	assign free      = !valid_q || !res_stall;
	assign res_valid = valid_q;
	assign res       = data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (!res_stall) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			data_q <= load_data;
		end
	end

endmodule

### design/tar_header_stream_scanner.sv
// Top level of the tar header stream scanner: input register, scanner, result register.
//
//  channel  | direction | handshake                | payload
//  ---------+-----------+--------------------------+-----------------------------
//  item     | in        | item_valid / item_stall  | in_item_t: data_byte, last_byte
//  res      | out       | res_valid / res_stall    | out_item_t: kind .. entry_index
//
// One archive byte per cycle, but for the stall below; results leave from a register.
// The input register feeds the scanner state update and the result register together.
// Reset (arst_n low) empties both registers and returns the scanner to the first header.
// A byte that yields a result waits in the input register while the result register is
// full and stalled; bytes that yield no result keep flowing.
module tar_header_stream_scanner
	import ths_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      item_valid,
	output logic      item_stall,
	input  in_item_t  item,
	output logic      res_valid,
	input  logic      res_stall,
	output out_item_t res
);

	logic      valid_s1;
	in_item_t  item_s1;
	logic      hit;
	logic      go;
	logic      out_free;
	out_item_t result;

	// the held byte moves on unless its result has nowhere to go
	assign go         = valid_s1 && (!hit || out_free);
	assign item_stall = valid_s1 && !go;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item_valid && !item_stall) begin
			valid_s1 <= 1'b1;
		end else if (go) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (item_valid && !item_stall) begin
			item_s1 <= item;
		end
	end

	ths_scan u_scan (
		.clk     (clk),
		.arst_n  (arst_n),
		.step    (go),
		.item_s1 (item_s1),
		.hit     (hit),
		.result  (result)
	);

	ths_out_reg u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (go && hit),
		.load_data (result),
		.free      (out_free),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res       (res)
	);

	// input side only backs up behind a full, stalled result register
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		item_stall |-> (res_valid && res_stall))
		else $error("input stalled without a blocked result");

	// directories report zero offset and size
	a_dir_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && res.is_directory) |-> (res.data_start == '0 && res.file_bytes == '0))
		else $error("directory result with nonzero offset or size");

	// only entries carry the directory flag or payload fields
	a_terminal_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && res.kind != KIND_ENTRY) |->
		(!res.is_directory && res.data_start == '0 && res.file_bytes == '0))
		else $error("terminal result with entry fields set");

	// a held result is replaced only after the sink takes it
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && res_stall) |=> res_valid)
		else $error("held result dropped");

endmodule
